[src/ctf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctf_pkg: shared types and constants of the complementary tilt filter
// Holds cell bus structs, the arctangent table, register indexes and states.
// ----------------------------------------------------------------------------
package ctf_pkg;

  // Input sample field width
  localparam int IN_W = 16;

  // Square root cells: 48-bit radicand, one root bit per cell
  localparam int SQ_RAD_W  = 48;
  localparam int SQ_REM_W  = 26;
  localparam int SQ_ROOT_W = 24;

  // CORDIC datapath width, Q.24 angles
  localparam int CW       = 28;
  localparam int ATAN_LEN = 24;

  // Configuration
  localparam int WEIGHT_W   = 17;
  localparam int PERIOD_W   = 24;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 1;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = 17'd65536;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 17'd64225;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 24'd16777;

  // atan(2^-i) in Q.24, rounded
  localparam logic [CW-1:0] ATAN_TAB [ATAN_LEN] = '{
    28'd13176795, 28'd7778716, 28'd4110060, 28'd2086331,
    28'd1047214,  28'd524117,  28'd262123,  28'd131069,
    28'd65536,    28'd32768,   28'd16384,   28'd8192,
    28'd4096,     28'd2048,    28'd1024,    28'd512,
    28'd256,      28'd128,     28'd64,      28'd32,
    28'd16,       28'd8,       28'd4,       28'd2
  };

  // Which tilt angle travels through the chains
  localparam logic TAG_ROLL  = 1'b0;
  localparam logic TAG_PITCH = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLEND_WEIGHT  = 1'b0,
    REG_SAMPLE_PERIOD = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic                    vld;
    logic                    tag;
    logic signed [IN_W-1:0]  num;
    logic [SQ_RAD_W-1:0]     rad;
    logic [SQ_REM_W-1:0]     rem;
    logic [SQ_ROOT_W-1:0]    root;
  } sq_bus_t;

  typedef struct packed {
    logic                 vld;
    logic                 tag;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cd_bus_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FEED_ROLL,
    S_FEED_PITCH,
    S_WAIT,
    S_INC,
    S_GYRO,
    S_MUL_G,
    S_MUL_A,
    S_MIX
  } state_t;

endpackage

[src/ctf_sqrt_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctf_sqrt_cell: one digit cell of the square root chain
// Takes the next two radicand bits, decides one root bit, registers the result.
// ----------------------------------------------------------------------------
module ctf_sqrt_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  ctf_pkg::sq_bus_t  d_in,
  output ctf_pkg::sq_bus_t  d_out
);

  logic [ctf_pkg::SQ_REM_W+1:0] rem_sh;
  logic [ctf_pkg::SQ_REM_W+1:0] trial;
  logic [ctf_pkg::SQ_REM_W+1:0] diff;
  ctf_pkg::sq_bus_t             q_nxt;
  ctf_pkg::sq_bus_t             q_r;

  // Restoring root step on the next digit pair
  always_comb begin
    rem_sh = {d_in.rem, d_in.rad[ctf_pkg::SQ_RAD_W-1 -: 2]};
    trial  = {2'b00, d_in.root, 2'b01};
    diff   = rem_sh - trial;
    q_nxt     = d_in;
    q_nxt.rad = {d_in.rad[ctf_pkg::SQ_RAD_W-3:0], 2'b00};
    if (rem_sh >= trial) begin
      q_nxt.rem  = diff[ctf_pkg::SQ_REM_W-1:0];
      q_nxt.root = {d_in.root[ctf_pkg::SQ_ROOT_W-2:0], 1'b1};
    end else begin
      q_nxt.rem  = rem_sh[ctf_pkg::SQ_REM_W-1:0];
      q_nxt.root = {d_in.root[ctf_pkg::SQ_ROOT_W-2:0], 1'b0};
    end
  end

  // Hand to the next cell
  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    if (!rst_n) begin
      q_r.vld <= 1'b0;
    end
  end

  assign d_out = q_r;

endmodule

[src/ctf_cordic_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctf_cordic_cell: one vectoring CORDIC rotation
// Rotates toward y = 0 by atan(2^-IDX) and accumulates the angle.
// ----------------------------------------------------------------------------
module ctf_cordic_cell #(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ctf_pkg::cd_bus_t  d_in,
  output ctf_pkg::cd_bus_t  d_out
);

  localparam logic signed [ctf_pkg::CW-1:0] ANG = $signed(ctf_pkg::ATAN_TAB[IDX]);

  logic signed [ctf_pkg::CW-1:0] xs;
  logic signed [ctf_pkg::CW-1:0] ys;
  ctf_pkg::cd_bus_t              q_nxt;
  ctf_pkg::cd_bus_t              q_r;

  // Rotate by the sign of y; y of zero leaves the vector alone
  always_comb begin
    xs    = d_in.x >>> IDX;
    ys    = d_in.y >>> IDX;
    q_nxt = d_in;
    priority if (d_in.y[ctf_pkg::CW-1]) begin
      q_nxt.x = d_in.x - ys;
      q_nxt.y = d_in.y + xs;
      q_nxt.z = d_in.z - ANG;
    end else if (d_in.y != '0) begin
      q_nxt.x = d_in.x + ys;
      q_nxt.y = d_in.y - xs;
      q_nxt.z = d_in.z + ANG;
    end else begin
      q_nxt = d_in;
    end
  end

  // Hand to the next cell
  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    if (!rst_n) begin
      q_r.vld <= 1'b0;
    end
  end

  assign d_out = q_r;

endmodule

[src/complementary_tilt_filter_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complementary_tilt_filter_unit: roll and pitch complementary filter
// Fuses integrated gyro rates with accelerometer tilt angles.
// ----------------------------------------------------------------------------
// One sample is worked on at a time: the accelerometer magnitudes pass a
// 24-cell square root chain, then a CORDIC chain of CORDIC_ITERATIONS cells
// (at most 24; roll first, pitch in the cycle after), and the blend spreads
// its multiplies over ten sequencer steps. A new sample is taken as soon as
// the sequencer is back in idle, even while the last result still waits in
// the output register. Weight above 1.0 is treated as 1.0.
module complementary_tilt_filter_unit #(
  parameter int CORDIC_ITERATIONS = 16,
  parameter int ANGLE_WIDTH       = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [ctf_pkg::IN_W-1:0]    in_gyro_roll_rate,
  input  logic signed [ctf_pkg::IN_W-1:0]    in_gyro_pitch_rate,
  input  logic signed [ctf_pkg::IN_W-1:0]    in_accel_x,
  input  logic signed [ctf_pkg::IN_W-1:0]    in_accel_y,
  input  logic signed [ctf_pkg::IN_W-1:0]    in_accel_z,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [ANGLE_WIDTH-1:0]      out_roll_angle,
  output logic signed [ANGLE_WIDTH-1:0]      out_pitch_angle,
  input  logic                               cfg_wr_en,
  input  logic [ctf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ctf_pkg::CFG_DATA_W-1:0]     cfg_wr_data
);

  localparam int NIT = (CORDIC_ITERATIONS > ctf_pkg::ATAN_LEN) ?
                       ctf_pkg::ATAN_LEN : CORDIC_ITERATIONS;
  localparam int AW  = ANGLE_WIDTH;
  localparam int CW  = ctf_pkg::CW;
  // CORDIC Q.24 to angle format
  localparam int ZS  = 27 - AW;
  localparam int ZSR = (ZS > 0) ? ZS : 1;
  localparam int ZSL = (ZS > 0) ? 0 : -ZS;
  // Gyro increment: Q.36 product to angle format
  localparam int IS  = 39 - AW;
  localparam int PW  = 41;
  localparam int GW  = AW + 4;
  localparam int MW  = AW + 24;
  localparam int XW  = MW - 16;
  localparam int SQW = 2 * ctf_pkg::IN_W;
  localparam logic signed [XW-1:0] SAT_HI = XW'((64'sd1 <<< (AW - 1)) - 64'sd1);
  localparam logic signed [XW-1:0] SAT_LO = XW'(-(64'sd1 <<< (AW - 1)));

  // Configuration registers
  logic [ctf_pkg::WEIGHT_W-1:0] weight_r;
  logic [ctf_pkg::PERIOD_W-1:0] period_r;
  logic [ctf_pkg::WEIGHT_W-1:0] w_eff;
  logic [ctf_pkg::WEIGHT_W-1:0] w_cmp;

  // Captured sample
  logic signed [ctf_pkg::IN_W-1:0] gr_r, gp_r, ax_r, ay_r, az_r;

  // Square stage
  logic signed [ctf_pkg::IN_W-1:0] opa, opb, opn;
  logic [SQW-1:0]                  sqa_r, sqb_r;
  logic signed [ctf_pkg::IN_W-1:0] num_r;
  logic                            sq_vld_r;
  logic                            sq_tag_r;
  logic [SQW-1:0]                  sq_sum;

  ctf_pkg::sq_bus_t sq_link [ctf_pkg::SQ_ROOT_W+1];
  ctf_pkg::cd_bus_t cd_link [NIT+1];

  // Angle rounding
  logic signed [63:0]   z_ext, z_scl;
  logic signed [AW-1:0] acc_ang, acc_neg;

  // Sequencer
  ctf_pkg::state_t state_r, state_nxt;
  logic            axis_r, axis_nxt;
  logic signed [AW-1:0] roll_acc_r, roll_acc_nxt, pitch_acc_r, pitch_acc_nxt;
  logic signed [AW-1:0] roll_est_r, roll_est_nxt, pitch_est_r, pitch_est_nxt;
  logic signed [PW-1:0] prod_r, prod_nxt;
  logic signed [GW-1:0] g_r, g_nxt;
  logic signed [MW-1:0] m1_r, m1_nxt, m2_r, m2_nxt;
  logic signed [AW-1:0] out_roll_r, out_roll_nxt, out_pitch_r, out_pitch_nxt;
  logic                 out_valid_r, out_valid_nxt;

  // Blend datapath
  logic signed [ctf_pkg::IN_W-1:0] rate_sel;
  logic signed [AW-1:0]            est_sel, acc_sel;
  logic signed [PW:0]              psum;
  logic signed [PW:0]              inc;
  logic signed [MW-1:0]            msum;
  logic signed [XW-1:0]            mix;
  logic signed [AW-1:0]            sat_val;
  logic                            in_xfer;

  assign in_xfer = in_valid && !in_stall;
  assign in_stall = (state_r != ctf_pkg::S_IDLE);

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r <= ctf_pkg::WEIGHT_RESET;
      period_r <= ctf_pkg::PERIOD_RESET;
    end else if (cfg_wr_en) begin
      unique case (ctf_pkg::cfg_reg_t'(cfg_index))
        ctf_pkg::REG_BLEND_WEIGHT:  weight_r <= cfg_wr_data[ctf_pkg::WEIGHT_W-1:0];
        ctf_pkg::REG_SAMPLE_PERIOD: period_r <= cfg_wr_data[ctf_pkg::PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  assign w_eff = (weight_r > ctf_pkg::WEIGHT_ONE) ? ctf_pkg::WEIGHT_ONE : weight_r;
  assign w_cmp = ctf_pkg::WEIGHT_ONE - w_eff;

  // Capture the sample on transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      gr_r <= in_gyro_roll_rate;
      gp_r <= in_gyro_pitch_rate;
      ax_r <= in_accel_x;
      ay_r <= in_accel_y;
      az_r <= in_accel_z;
    end
  end

  // Square the two magnitude axes of the angle being fed
  always_comb begin
    if (state_r == ctf_pkg::S_FEED_ROLL) begin
      opa = ax_r;
      opn = ay_r;
    end else begin
      opa = ay_r;
      opn = ax_r;
    end
    opb = az_r;
  end

  always_ff @(posedge clk) begin
    sqa_r <= SQW'(SQW'(opa) * SQW'(opa));
    sqb_r <= SQW'(SQW'(opb) * SQW'(opb));
    num_r <= opn;
    sq_tag_r <= (state_r == ctf_pkg::S_FEED_ROLL) ? ctf_pkg::TAG_ROLL : ctf_pkg::TAG_PITCH;
    if (!rst_n) begin
      sq_vld_r <= 1'b0;
    end else begin
      sq_vld_r <= (state_r == ctf_pkg::S_FEED_ROLL) || (state_r == ctf_pkg::S_FEED_PITCH);
    end
  end

  // Square root chain head: (a*a + b*b) << 16
  assign sq_sum = sqa_r + sqb_r;
  always_comb begin
    sq_link[0].vld  = sq_vld_r;
    sq_link[0].tag  = sq_tag_r;
    sq_link[0].num  = num_r;
    sq_link[0].rad  = {sq_sum, {(ctf_pkg::SQ_RAD_W - SQW){1'b0}}};
    sq_link[0].rem  = '0;
    sq_link[0].root = '0;
  end

  for (genvar k = 0; k < ctf_pkg::SQ_ROOT_W; k++) begin : g_sqrt
    ctf_sqrt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .d_in  (sq_link[k]),
      .d_out (sq_link[k+1])
    );
  end

  // CORDIC chain head: x = magnitude, y = numerator << 8
  always_comb begin
    cd_link[0].vld = sq_link[ctf_pkg::SQ_ROOT_W].vld;
    cd_link[0].tag = sq_link[ctf_pkg::SQ_ROOT_W].tag;
    cd_link[0].x   = $signed({{(CW - ctf_pkg::SQ_ROOT_W){1'b0}},
                              sq_link[ctf_pkg::SQ_ROOT_W].root});
    cd_link[0].y   = $signed({{(CW - ctf_pkg::IN_W - 8){sq_link[ctf_pkg::SQ_ROOT_W].num[15]}},
                              sq_link[ctf_pkg::SQ_ROOT_W].num, 8'h00});
    cd_link[0].z   = '0;
  end

  for (genvar k = 0; k < NIT; k++) begin : g_cordic
    ctf_cordic_cell #(.IDX(k)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .d_in  (cd_link[k]),
      .d_out (cd_link[k+1])
    );
  end

  // Round the CORDIC angle to the angle format
  always_comb begin
    z_ext = 64'(cd_link[NIT].z);
    if (ZS > 0) begin
      z_scl = (z_ext + (64'sd1 <<< (ZSR - 1))) >>> ZSR;
    end else begin
      z_scl = z_ext <<< ZSL;
    end
    acc_ang = AW'(z_scl);
    acc_neg = AW'(-z_scl);
  end

  // Blend datapath
  always_comb begin
    rate_sel = (axis_r == ctf_pkg::TAG_ROLL) ? gr_r : gp_r;
    est_sel  = (axis_r == ctf_pkg::TAG_ROLL) ? roll_est_r : pitch_est_r;
    acc_sel  = (axis_r == ctf_pkg::TAG_ROLL) ? roll_acc_r : pitch_acc_r;
    psum     = $signed({prod_r[PW-1], prod_r}) + (PW+1)'(64'sd1 <<< (IS - 1));
    inc      = psum >>> IS;
    msum     = m1_r + m2_r + MW'(32768);
    mix      = XW'(msum >>> 16);
    priority if (mix > SAT_HI) begin
      sat_val = AW'(SAT_HI);
    end else if (mix < SAT_LO) begin
      sat_val = AW'(SAT_LO);
    end else begin
      sat_val = AW'(mix);
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ctf_pkg::S_IDLE;
      axis_r      <= ctf_pkg::TAG_ROLL;
      roll_est_r  <= '0;
      pitch_est_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      axis_r      <= axis_nxt;
      roll_est_r  <= roll_est_nxt;
      pitch_est_r <= pitch_est_nxt;
      out_valid_r <= out_valid_nxt;
    end
    roll_acc_r  <= roll_acc_nxt;
    pitch_acc_r <= pitch_acc_nxt;
    prod_r      <= prod_nxt;
    g_r         <= g_nxt;
    m1_r        <= m1_nxt;
    m2_r        <= m2_nxt;
    out_roll_r  <= out_roll_nxt;
    out_pitch_r <= out_pitch_nxt;
  end

  // Next state and datapath loads
  always_comb begin
    state_nxt     = state_r;
    axis_nxt      = axis_r;
    roll_acc_nxt  = roll_acc_r;
    pitch_acc_nxt = pitch_acc_r;
    roll_est_nxt  = roll_est_r;
    pitch_est_nxt = pitch_est_r;
    prod_nxt      = prod_r;
    g_nxt         = g_r;
    m1_nxt        = m1_r;
    m2_nxt        = m2_r;
    out_roll_nxt  = out_roll_r;
    out_pitch_nxt = out_pitch_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      ctf_pkg::S_IDLE: begin
        if (in_xfer) begin
          state_nxt = ctf_pkg::S_FEED_ROLL;
        end
      end
      ctf_pkg::S_FEED_ROLL:  state_nxt = ctf_pkg::S_FEED_PITCH;
      ctf_pkg::S_FEED_PITCH: state_nxt = ctf_pkg::S_WAIT;
      ctf_pkg::S_WAIT: begin
        // Collect roll, then pitch in the cycle after
        if (cd_link[NIT].vld) begin
          if (cd_link[NIT].tag == ctf_pkg::TAG_ROLL) begin
            roll_acc_nxt = acc_ang;
          end else begin
            pitch_acc_nxt = acc_neg;
            axis_nxt      = ctf_pkg::TAG_ROLL;
            state_nxt     = ctf_pkg::S_INC;
          end
        end
      end
      ctf_pkg::S_INC: begin
        prod_nxt  = PW'(rate_sel) * PW'($signed({1'b0, period_r}));
        state_nxt = ctf_pkg::S_GYRO;
      end
      ctf_pkg::S_GYRO: begin
        g_nxt     = GW'(est_sel) + GW'(inc);
        state_nxt = ctf_pkg::S_MUL_G;
      end
      ctf_pkg::S_MUL_G: begin
        m1_nxt    = MW'(g_r) * MW'($signed({1'b0, w_eff}));
        state_nxt = ctf_pkg::S_MUL_A;
      end
      ctf_pkg::S_MUL_A: begin
        m2_nxt    = MW'(acc_sel) * MW'($signed({1'b0, w_cmp}));
        state_nxt = ctf_pkg::S_MIX;
      end
      ctf_pkg::S_MIX: begin
        if (axis_r == ctf_pkg::TAG_ROLL) begin
          roll_est_nxt = sat_val;
          axis_nxt     = ctf_pkg::TAG_PITCH;
          state_nxt    = ctf_pkg::S_INC;
        end else if (!(out_valid_r && out_stall)) begin
          // Hold until the previous result is taken
          pitch_est_nxt = sat_val;
          out_roll_nxt  = roll_est_r;
          out_pitch_nxt = sat_val;
          out_valid_nxt = 1'b1;
          state_nxt     = ctf_pkg::S_IDLE;
        end
      end
      default: state_nxt = ctf_pkg::S_IDLE;
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_roll_angle  = out_roll_r;
  assign out_pitch_angle = out_pitch_r;

  // Checks
  a_accept_feeds: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> state_r == ctf_pkg::S_FEED_ROLL)
    else $error("transfer did not start the feed");

  a_sq_entry: assert property (@(posedge clk) disable iff (!rst_n)
    sq_vld_r |-> ($past(state_r) == ctf_pkg::S_FEED_ROLL ||
                  $past(state_r) == ctf_pkg::S_FEED_PITCH))
    else $error("square root chain entered outside the feed");

  a_cordic_drain: assert property (@(posedge clk) disable iff (!rst_n)
    cd_link[NIT].vld |-> state_r == ctf_pkg::S_WAIT)
    else $error("tilt angle left the chain while not waiting");

  a_out_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ctf_pkg::S_MIX &&
                            $past(axis_r) == ctf_pkg::TAG_PITCH))
    else $error("result raised outside the final blend step");

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the complementary tilt filter unit
// Drives IMU samples over the valid/stall input channel, predicts each fused
// roll and pitch pair in a local integer model of the filter and compares
// every result transfer against it, across several weight and period settings.
// ----------------------------------------------------------------------------
module testbench;

  localparam int AW        = 16;
  localparam int IN_W      = ctf_pkg::IN_W;
  localparam int WDOG_MAX  = 5000;
  localparam int HOLD_LEN  = 500;
  localparam int SETTLE    = 100;
  localparam int N_PHASE   = 7;
  localparam int PHASE_LEN = 250;

  typedef struct {
    logic signed [IN_W-1:0] gr, gp, ax, ay, az;
  } sample_t;

  typedef struct {
    logic signed [AW-1:0] roll, pitch;
  } angles_t;

  typedef struct {
    sample_t              s;
    bit                   typed;
    logic signed [AW-1:0] roll, pitch;
  } vector_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic signed [IN_W-1:0]          in_gyro_roll_rate = '0;
  logic signed [IN_W-1:0]          in_gyro_pitch_rate = '0;
  logic signed [IN_W-1:0]          in_accel_x = '0;
  logic signed [IN_W-1:0]          in_accel_y = '0;
  logic signed [IN_W-1:0]          in_accel_z = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic signed [AW-1:0]            out_roll_angle;
  logic signed [AW-1:0]            out_pitch_angle;
  logic                            cfg_wr_en = 1'b0;
  logic [ctf_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
  logic [ctf_pkg::CFG_DATA_W-1:0]  cfg_wr_data = '0;

  // Predictor state and configuration
  logic [ctf_pkg::WEIGHT_W-1:0]    mdl_weight;
  logic [ctf_pkg::PERIOD_W-1:0]    mdl_period;
  longint                          mdl_roll, mdl_pitch;

  angles_t                 pending_angles[$];
  int                      err_cnt = 0;
  int                      idle_cycles = 0;
  bit                      quiet = 1'b0;
  bit                      hold_req = 1'b0;

  complementary_tilt_filter_unit DUT (.*);

  // Clock: 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // atan2(num, hypot(a, b)) in Q3.13 via integer root and vectoring CORDIC
  function automatic longint tilt_angle(longint num, longint a, longint b);
    longint unsigned n, root, bitv;
    longint x, y, z, xs, ys;
    n = longint'(a * a + b * b) << 16;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    x = longint'(root);
    y = num * 256;
    z = 0;
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += longint'(ctf_pkg::ATAN_TAB[i]);
      end else if (y < 0) begin
        x -= ys; y += xs; z -= longint'(ctf_pkg::ATAN_TAB[i]);
      end
    end
    return (z + 1024) >>> 11;
  endfunction

  // Integrate the rate onto the estimate, blend with the tilt, saturate
  function automatic longint blend_axis(longint est, longint rate, longint acc);
    longint w, inc, mix;
    w = (mdl_weight > ctf_pkg::WEIGHT_ONE) ? 65536 : longint'(mdl_weight);
    inc = (rate * longint'(mdl_period) + (64'sd1 <<< 22)) >>> 23;
    mix = (w * (est + inc) + (65536 - w) * acc + 32768) >>> 16;
    if (mix > 32767) mix = 32767;
    if (mix < -32768) mix = -32768;
    return mix;
  endfunction

  function automatic angles_t predict_angles(sample_t s);
    angles_t r;
    longint roll_t, pitch_t;
    roll_t = tilt_angle(s.ay, s.ax, s.az);
    pitch_t = -tilt_angle(s.ax, s.ay, s.az);
    mdl_roll = blend_axis(mdl_roll, s.gr, roll_t);
    mdl_pitch = blend_axis(mdl_pitch, s.gp, pitch_t);
    r.roll = mdl_roll[AW-1:0];
    r.pitch = mdl_pitch[AW-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  // Present one sample and hold it until its transfer
  task automatic send_sample(sample_t s, bit typed = 1'b0, angles_t given = '{0, 0});
    angles_t a;
    in_valid <= 1'b1;
    in_gyro_roll_rate <= s.gr;
    in_gyro_pitch_rate <= s.gp;
    in_accel_x <= s.ax;
    in_accel_y <= s.ay;
    in_accel_z <= s.az;
    do @(posedge clk); while (in_stall);
    a = predict_angles(s);
    pending_angles.push_back(typed ? given : a);
  endtask

  // Random gap on the input side, none in the quiet tail
  task automatic maybe_gap();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // Wait for all results, let the unit settle, then write one register
  task automatic write_reg(ctf_pkg::cfg_reg_t idx, logic [ctf_pkg::CFG_DATA_W-1:0] val);
    in_valid <= 1'b0;
    while (pending_angles.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wr_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == ctf_pkg::REG_BLEND_WEIGHT) mdl_weight = val[ctf_pkg::WEIGHT_W-1:0];
    else mdl_period = val[ctf_pkg::PERIOD_W-1:0];
  endtask

  function automatic logic signed [IN_W-1:0] pick_edge();
    case ($urandom_range(0, 3))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'sh0000;
      default: return 16'shFFFF;
    endcase
  endfunction

  // Mostly plausible motion, plus full-range, free-fall and edge samples
  function automatic sample_t random_sample();
    sample_t s;
    int k;
    k = $urandom_range(0, 9);
    if (k <= 5) begin
      s.gr = IN_W'(int'($urandom_range(0, 4000)) - 2000);
      s.gp = IN_W'(int'($urandom_range(0, 4000)) - 2000);
      s.ax = IN_W'(int'($urandom_range(0, 5200)) - 2600);
      s.ay = IN_W'(int'($urandom_range(0, 5200)) - 2600);
      s.az = IN_W'(int'($urandom_range(0, 5200)) - 2600);
    end else if (k <= 7) begin
      s.gr = IN_W'($urandom); s.gp = IN_W'($urandom);
      s.ax = IN_W'($urandom); s.ay = IN_W'($urandom); s.az = IN_W'($urandom);
    end else if (k == 8) begin
      s.gr = IN_W'($urandom); s.gp = IN_W'($urandom);
      s.ax = '0; s.ay = '0; s.az = '0;
    end else begin
      s.gr = pick_edge(); s.gp = pick_edge();
      s.ax = pick_edge(); s.ay = pick_edge(); s.az = pick_edge();
    end
    return s;
  endfunction

  // Directed samples; typed rows carry an expectation known by inspection
  vector_t directed[] = '{
    '{'{0, 0, 0, 0, 0}, 1'b1, 0, 0},
    '{'{0, 0, 0, 0, 2509}, 1'b1, 0, 0},
    '{'{0, 0, 0, 0, -2509}, 1'b1, 0, 0},
    '{'{0, 0, 2509, 0, 0}, 1'b0, 0, 0},
    '{'{0, 0, 0, 2509, 0}, 1'b0, 0, 0},
    '{'{0, 0, -2509, -2509, 100}, 1'b0, 0, 0},
    '{'{16'sh7FFF, 16'sh8000, 0, 0, 2509}, 1'b0, 0, 0},
    '{'{16'sh8000, 16'sh7FFF, 0, 0, 2509}, 1'b0, 0, 0},
    '{'{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF}, 1'b0, 0, 0},
    '{'{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000}, 1'b0, 0, 0},
    '{'{0, 0, 16'sh8000, 0, 0}, 1'b0, 0, 0},
    '{'{0, 0, 0, 16'sh8000, 0}, 1'b0, 0, 0},
    '{'{0, 0, 16'sh7FFF, 16'sh8000, 0}, 1'b0, 0, 0},
    '{'{16'shFFFF, 1, 1, 16'shFFFF, 16'sh5555}, 1'b0, 0, 0},
    '{'{16'sh5555, 16'shAAAA, 16'shAAAA, 16'sh5555, 16'shAAAA}, 1'b0, 0, 0}
  };

  // Weight and period per random phase; the extremes and special cases
  logic [ctf_pkg::CFG_DATA_W-1:0] phase_weight[N_PHASE] = '{
    24'd65536, 24'd0, 24'd131071, 24'd32768, 24'd65537, 24'd1, 24'd64225
  };
  logic [ctf_pkg::CFG_DATA_W-1:0] phase_period[N_PHASE] = '{
    24'd16777, 24'd1, 24'd16777215, 24'd0, 24'd1048576, 24'd16777215, 24'd16777
  };

  // Stimulus
  initial begin
    vector_t v;
    mdl_weight = ctf_pkg::WEIGHT_RESET;
    mdl_period = ctf_pkg::PERIOD_RESET;
    mdl_roll = 0;
    mdl_pitch = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under the reset settings
    foreach (directed[i]) begin
      v = directed[i];
      send_sample(v.s, v.typed, '{v.roll, v.pitch});
      maybe_gap();
    end

    // Random phases, one setting each
    for (int p = 0; p < N_PHASE; p++) begin
      write_reg(ctf_pkg::REG_BLEND_WEIGHT, phase_weight[p]);
      write_reg(ctf_pkg::REG_SAMPLE_PERIOD, phase_period[p]);
      quiet = (p == N_PHASE - 1);
      if (p == 1) hold_req = 1'b1;
      for (int n = 0; n < PHASE_LEN; n++) begin
        send_sample(random_sample());
        maybe_gap();
      end
    end
    in_valid <= 1'b0;

    // Drain and settle
    while (pending_angles.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    foreach (pending_angles[i]) report_mismatch("leftover result", 0, 0);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Result side stall: random bursts, one long hold-off, none in the tail
  initial begin
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_LEN) @(posedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // Check each result transfer against the oldest expectation
  always @(posedge clk) begin
    angles_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_angles.size() == 0) begin
        report_mismatch("unexpected result roll", out_roll_angle, 0);
      end else begin
        want = pending_angles.pop_front();
        if (out_roll_angle !== want.roll)
          report_mismatch("roll_angle", out_roll_angle, want.roll);
        if (out_pitch_angle !== want.pitch)
          report_mismatch("pitch_angle", out_pitch_angle, want.pitch);
      end
    end
  end

  // Watchdog: count cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_MAX) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

endmodule
